@@ hdl/lfps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared widths, register indexes, reset values and the pattern table of the
// five-sensor line follower steering unit.
// ----------------------------------------------------------------------------
package lfps_pkg;

  localparam int NumSensors = 5;
  localparam int SampleW    = 12;
  localparam int GainW      = 8;
  localparam int ErrW       = 4;
  localparam int PatW       = 5;
  localparam int StopW      = 3;
  localparam int DutyW      = 8;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 12;

  // product and sum widths
  localparam int PropW = GainW + 1 + ErrW;        // kp * err
  localparam int DiffW = ErrW + 1;                // err - last_err
  localparam int DerW  = GainW + 1 + DiffW;       // kd * diff
  localparam int SumW  = DerW + 15;               // kd * diff * 10000 + kp * err

  localparam logic signed [SumW-1:0] DerivScale = SumW'(10000);
  localparam logic signed [SumW-1:0] CorrLimit  = SumW'(100);
  localparam logic signed [8:0]      DutyBase   = 9'sd100;
  localparam logic [DutyW-1:0]       DutyCenter = 8'd50;
  localparam logic [PatW-1:0]        AllDark    = 5'd31;
  localparam logic [StopW-1:0]       StopHalt   = 3'd2;
  localparam logic [StopW-1:0]       StopMax    = 3'd7;

  localparam logic [SampleW-1:0] ThrReset [NumSensors] =
    '{12'd1961, 12'd1958, 12'd1959, 12'd1957, 12'd1959};
  localparam logic [GainW-1:0] PropGainReset  = 8'd20;
  localparam logic [GainW-1:0] DerivGainReset = 8'd5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegThr0  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegThr1  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegThr2  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegThr3  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegThr4  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPGain = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDGain = 3'd6;

  typedef struct packed {
    logic load;   // latch pattern, update error and stop state
    logic mult;   // form both products
    logic sum;    // combine products
    logic emit;   // clamp, select duties, load output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic                   hit;
    logic signed [ErrW-1:0] err;
  } lookup_t;

  function automatic lookup_t lookup_error(input logic [PatW-1:0] pat);
    lookup_t r;
    r.hit = 1'b1;
    r.err = '0;
    unique case (pat)
      5'd4:    r.err = 4'sd0;
      5'd1:    r.err = -4'sd4;
      5'd3:    r.err = -4'sd3;
      5'd2:    r.err = -4'sd2;
      5'd6:    r.err = -4'sd1;
      5'd12:   r.err = 4'sd1;
      5'd8:    r.err = 4'sd2;
      5'd24:   r.err = 4'sd3;
      5'd16:   r.err = 4'sd4;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/lfps_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_ctrl
// Sequencer of the steering unit: load, multiply, sum and emit steps.
// ----------------------------------------------------------------------------
module lfps_ctrl
  import lfps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MULT = 4'b0010,
    S_SUM  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = S_MULT;
      end
      S_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        cmd_o.emit = status_i.out_free;
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("emit while output register busy");

  a_load_to_mult: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.mult ##1 cmd_o.sum)
    else $error("step sequence broken after load");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.mult, cmd_o.sum, cmd_o.emit}))
    else $error("more than one step command");

endmodule

@@ hdl/lfps_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_datapath
// Thresholds, gains, error and stop state, PD arithmetic and output register.
// ----------------------------------------------------------------------------
module lfps_datapath
  import lfps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  input  logic [SampleW-1:0]    sample_0_i,
  input  logic [SampleW-1:0]    sample_1_i,
  input  logic [SampleW-1:0]    sample_2_i,
  input  logic [SampleW-1:0]    sample_3_i,
  input  logic [SampleW-1:0]    sample_4_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [DutyW-1:0]      left_duty_o,
  output logic [DutyW-1:0]      right_duty_o,
  output logic signed [ErrW-1:0] line_error_o,
  output logic [StopW-1:0]      stop_marks_o
);

  logic [SampleW-1:0] thr_q [NumSensors];
  logic [GainW-1:0]   kp_q, kd_q;

  logic signed [ErrW-1:0] cur_err_q, last_err_q;
  logic [PatW-1:0]        last_pat_q;
  logic [StopW-1:0]       stop_q;

  logic signed [PropW-1:0] prop_q;
  logic signed [DerW-1:0]  der_q;
  logic signed [SumW-1:0]  sum_q;

  logic                   out_valid_q;
  logic [DutyW-1:0]       left_q, right_q;
  logic signed [ErrW-1:0] err_out_q;
  logic [StopW-1:0]       stop_out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSensors; i++) thr_q[i] <= ThrReset[i];
      kp_q <= PropGainReset;
      kd_q <= DerivGainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegThr0:  thr_q[0] <= cfg_data_i;
        RegThr1:  thr_q[1] <= cfg_data_i;
        RegThr2:  thr_q[2] <= cfg_data_i;
        RegThr3:  thr_q[3] <= cfg_data_i;
        RegThr4:  thr_q[4] <= cfg_data_i;
        RegPGain: kp_q <= cfg_data_i[GainW-1:0];
        RegDGain: kd_q <= cfg_data_i[GainW-1:0];
        default:  ;
      endcase
    end
  end

  // pattern and table lookup
  logic [PatW-1:0]        pat;
  lookup_t                lk;
  logic signed [ErrW-1:0] cur_err_d;
  logic [StopW-1:0]       stop_d;

  always_comb begin
    pat[0] = sample_0_i < thr_q[0];
    pat[1] = sample_1_i < thr_q[1];
    pat[2] = sample_2_i < thr_q[2];
    pat[3] = sample_3_i < thr_q[3];
    pat[4] = sample_4_i < thr_q[4];
    lk        = lookup_error(pat);
    cur_err_d = lk.hit ? lk.err : cur_err_q;
    stop_d    = stop_q;
    // count only on entry into all-dark
    if (pat == AllDark && last_pat_q != AllDark && stop_q != StopMax) begin
      stop_d = stop_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_err_q  <= '0;
      last_err_q <= '0;
      last_pat_q <= '0;
      stop_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        cur_err_q  <= cur_err_d;
        last_pat_q <= pat;
        stop_q     <= stop_d;
      end
      if (cmd_i.mult) last_err_q <= cur_err_q;
    end
  end

  // products
  logic signed [DiffW-1:0] diff;
  logic signed [PropW-1:0] prop_d;
  logic signed [DerW-1:0]  der_d;

  always_comb begin
    diff   = DiffW'(cur_err_q) - DiffW'(last_err_q);
    prop_d = PropW'($signed({1'b0, kp_q})) * PropW'(cur_err_q);
    der_d  = DerW'($signed({1'b0, kd_q})) * DerW'(diff);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      prop_q <= prop_d;
      der_q  <= der_d;
    end
    if (cmd_i.sum) begin
      sum_q <= SumW'(der_q) * DerivScale + SumW'(prop_q);
    end
  end

  // clamp and duty selection
  logic signed [7:0] corr;
  logic signed [8:0] left_d, right_d;

  always_comb begin
    priority if (sum_q > CorrLimit) begin
      corr = 8'sd100;
    end else if (sum_q < -CorrLimit) begin
      corr = -8'sd100;
    end else begin
      corr = sum_q[7:0];
    end
    priority if (cur_err_q > 4'sd0) begin
      left_d  = DutyBase - 9'(corr);
      right_d = DutyBase;
    end else if (cur_err_q < 4'sd0) begin
      left_d  = DutyBase;
      right_d = DutyBase + 9'(corr);
    end else begin
      left_d  = 9'(DutyCenter);
      right_d = 9'(DutyCenter);
    end
    if (stop_q == StopHalt) begin
      left_d  = '0;
      right_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      left_q     <= left_d[DutyW-1:0];
      right_q    <= right_d[DutyW-1:0];
      err_out_q  <= cur_err_q;
      stop_out_q <= stop_q;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign left_duty_o  = left_q;
  assign right_duty_o = right_q;
  assign line_error_o = err_out_q;
  assign stop_marks_o = stop_out_q;

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (err_out_q >= -4'sd4 && err_out_q <= 4'sd4))
    else $error("line error out of range");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (left_q <= 8'd200 && right_q <= 8'd200))
    else $error("duty out of range");

  a_halt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && stop_out_q == StopHalt) |-> (left_q == '0 && right_q == '0))
    else $error("duties not zero at halt count");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("emitted transaction not shown");

endmodule

@@ hdl/line_follow_pd_steering_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_pd_steering_unit
// Five-sensor line follower: threshold pattern, error table, stop counting
// and clamped PD steering into left and right motor duties.
// Each transaction runs through the four-step sequencer (load, multiply,
// sum, emit) before its result is valid; a new one is taken only when the
// sequencer is idle again, and emit waits while the output register is full.
// Reset: asynchronous, active low; clears error, pattern and stop state and
// loads the default thresholds and gains.
// ----------------------------------------------------------------------------
module line_follow_pd_steering_unit
  import lfps_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SampleW-1:0]     sample_0_i,
  input  logic [SampleW-1:0]     sample_1_i,
  input  logic [SampleW-1:0]     sample_2_i,
  input  logic [SampleW-1:0]     sample_3_i,
  input  logic [SampleW-1:0]     sample_4_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [DutyW-1:0]       left_duty_o,
  output logic [DutyW-1:0]       right_duty_o,
  output logic signed [ErrW-1:0] line_error_o,
  output logic [StopW-1:0]       stop_marks_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lfps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lfps_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sample_0_i   (sample_0_i),
    .sample_1_i   (sample_1_i),
    .sample_2_i   (sample_2_i),
    .sample_3_i   (sample_3_i),
    .sample_4_i   (sample_4_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .left_duty_o  (left_duty_o),
    .right_duty_o (right_duty_o),
    .line_error_o (line_error_o),
    .stop_marks_o (stop_marks_o)
  );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line follower steering unit. Sample sets are
// built from wanted sensor patterns, both mid-range and exactly at the
// thresholds. A shadow of the error table, stop counter and PD correction
// predicts the duties, error and stop count of every transaction. Thresholds
// and gains change between phases while the unit is idle, and both handshake
// sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import lfps_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;  // no register behind it
  localparam int SteerBase    = 100;
  localparam int SteerCenter  = 50;
  localparam int SteerLimit   = 100;
  localparam int DerivMul     = 10000;
  localparam int NumPhases    = 8;
  localparam int SetsPerPhase = 137;

  localparam logic [PatW-1:0] LinePatterns [9] =
    '{5'd4, 5'd1, 5'd3, 5'd2, 5'd6, 5'd12, 5'd8, 5'd24, 5'd16};
  localparam logic [PatW-1:0] DirectedPatterns [11] =
    '{5'd4, 5'd1, 5'd16, 5'd3, 5'd2, 5'd6, 5'd12, 5'd8, 5'd24, 5'd16, 5'd16};

  typedef logic [NumSensors-1:0][SampleW-1:0] sample_set_t;

  typedef struct packed {
    logic [DutyW-1:0]       left;
    logic [DutyW-1:0]       right;
    logic signed [ErrW-1:0] err;
    logic [StopW-1:0]       marks;
  } steer_result_t;

  class steering_scoreboard;
    logic [SampleW-1:0]     thr [NumSensors];
    logic [GainW-1:0]       kp;
    logic [GainW-1:0]       kd;
    logic signed [ErrW-1:0] cur_err;
    logic signed [ErrW-1:0] last_err;
    logic [PatW-1:0]        last_pat;
    logic [StopW-1:0]       marks;
    steer_result_t          expected_duties [$];
    int unsigned            mismatches;

    function new();
      foreach (thr[i]) thr[i] = ThrReset[i];
      kp          = PropGainReset;
      kd          = DerivGainReset;
      cur_err     = '0;
      last_err    = '0;
      last_pat    = '0;
      marks       = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegThr0:  thr[0] = data;
        RegThr1:  thr[1] = data;
        RegThr2:  thr[2] = data;
        RegThr3:  thr[3] = data;
        RegThr4:  thr[4] = data;
        RegPGain: kp = data[GainW-1:0];
        RegDGain: kd = data[GainW-1:0];
        default:  ;
      endcase
    endfunction

    function bit line_position(logic [PatW-1:0] pat, output logic signed [ErrW-1:0] e);
      line_position = 1'b1;
      e = '0;
      case (pat)
        5'd4:    e = 4'sd0;
        5'd1:    e = -4'sd4;
        5'd3:    e = -4'sd3;
        5'd2:    e = -4'sd2;
        5'd6:    e = -4'sd1;
        5'd12:   e = 4'sd1;
        5'd8:    e = 4'sd2;
        5'd24:   e = 4'sd3;
        5'd16:   e = 4'sd4;
        default: line_position = 1'b0;
      endcase
    endfunction

    function void note_sample_set(sample_set_t s);
      logic [PatW-1:0]        pat;
      logic signed [ErrW-1:0] e;
      int                     kp_v, kd_v, err_v, last_v, corr, left, right;
      steer_result_t          r;
      pat = '0;
      for (int i = 0; i < NumSensors; i++) begin
        if (s[i] < thr[i]) pat[i] = 1'b1;
      end
      if (line_position(pat, e)) cur_err = e;
      if (pat == AllDark && last_pat != AllDark && marks != StopMax) marks = marks + 1'b1;
      last_pat = pat;
      kp_v   = kp;
      kd_v   = kd;
      err_v  = cur_err;
      last_v = last_err;
      corr = kp_v * err_v + kd_v * (err_v - last_v) * DerivMul;
      if (corr > SteerLimit) corr = SteerLimit;
      else if (corr < -SteerLimit) corr = -SteerLimit;
      if (err_v > 0) begin
        left  = SteerBase - corr;
        right = SteerBase;
      end else if (err_v < 0) begin
        left  = SteerBase;
        right = SteerBase + corr;
      end else begin
        left  = SteerCenter;
        right = SteerCenter;
      end
      if (marks == StopHalt) begin
        left  = 0;
        right = 0;
      end
      last_err = cur_err;
      r.left  = left[DutyW-1:0];
      r.right = right[DutyW-1:0];
      r.err   = cur_err;
      r.marks = marks;
      expected_duties.push_back(r);
    endfunction

    function void check_duties(steer_result_t got);
      steer_result_t exp_r;
      if (expected_duties.size() == 0) begin
        $error("result with no transaction waiting: left %0d right %0d",
               got.left, got.right);
        mismatches++;
        return;
      end
      exp_r = expected_duties.pop_front();
      if (got.left !== exp_r.left) begin
        $error("left_duty: expected %0d, got %0d", exp_r.left, got.left);
        mismatches++;
      end
      if (got.right !== exp_r.right) begin
        $error("right_duty: expected %0d, got %0d", exp_r.right, got.right);
        mismatches++;
      end
      if (got.err !== exp_r.err) begin
        $error("line_error: expected %0d, got %0d", exp_r.err, got.err);
        mismatches++;
      end
      if (got.marks !== exp_r.marks) begin
        $error("stop_marks: expected %0d, got %0d", exp_r.marks, got.marks);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_duties.size();
    endfunction
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i   = '0;
  logic [CfgDataW-1:0]    cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic [SampleW-1:0]     sample_0_i  = '0;
  logic [SampleW-1:0]     sample_1_i  = '0;
  logic [SampleW-1:0]     sample_2_i  = '0;
  logic [SampleW-1:0]     sample_3_i  = '0;
  logic [SampleW-1:0]     sample_4_i  = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b1;
  logic [DutyW-1:0]       left_duty_o;
  logic [DutyW-1:0]       right_duty_o;
  logic signed [ErrW-1:0] line_error_o;
  logic [StopW-1:0]       stop_marks_o;

  bit                     idle_on = 1'b1;
  steering_scoreboard     sb = new();

  line_follow_pd_steering_unit DUT (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Pick samples that give the wanted pattern, either anywhere in range or
  // right at the threshold (one below is dark, equal is not).
  function automatic sample_set_t samples_for(input logic [PatW-1:0] pat, input bit at_edge);
    sample_set_t s;
    int          t;
    for (int i = 0; i < NumSensors; i++) begin
      t = sb.thr[i];
      if (pat[i] && t != 0) s[i] = at_edge ? SampleW'(t - 1) : SampleW'($urandom_range(0, t - 1));
      else s[i] = at_edge ? SampleW'(t) : SampleW'($urandom_range(t, 4095));
    end
    return s;
  endfunction

  function automatic sample_set_t noise_samples();
    sample_set_t s;
    for (int i = 0; i < NumSensors; i++) s[i] = SampleW'($urandom_range(0, 4095));
    return s;
  endfunction

  task automatic drive_sample_set(input sample_set_t s);
    int gap;
    in_valid_i <= 1'b1;
    sample_0_i <= s[0];
    sample_1_i <= s[1];
    sample_2_i <= s[2];
    sample_3_i <= s[3];
    sample_4_i <= s[4];
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample_set(s);
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and hold until every transaction has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic setup_phase(input int p);
    sample_set_t         thr;
    logic [CfgDataW-1:0] kp, kd;
    bit                  poke;
    thr  = noise_samples();
    kp   = CfgDataW'($urandom);
    kd   = CfgDataW'($urandom);
    poke = 1'b0;
    case (p)
      1: begin
        thr = {NumSensors{12'd2048}};
        kp[GainW-1:0] = 8'd25;
        kd[GainW-1:0] = 8'd0;
      end
      3: begin
        thr = {NumSensors{12'd4095}};
        kp[GainW-1:0] = 8'd255;
        kd[GainW-1:0] = 8'd255;
      end
      4: begin
        thr = '0;
        kp[GainW-1:0] = 8'd0;
        kd[GainW-1:0] = 8'd0;
      end
      5: begin
        kp[GainW-1:0] = GainW'($urandom_range(0, 25));
        kd[GainW-1:0] = GainW'($urandom_range(0, 1));
      end
      6: begin
        kd[GainW-1:0] = 8'd0;
        poke = 1'b1;
      end
      7: begin
        kp[GainW-1:0] = 8'd1;
        kd[GainW-1:0] = 8'd1;
        poke = 1'b1;
      end
      default: ;
    endcase
    write_reg(RegThr0, thr[0]);
    write_reg(RegThr1, thr[1]);
    write_reg(RegThr2, thr[2]);
    write_reg(RegThr3, thr[3]);
    write_reg(RegThr4, thr[4]);
    write_reg(RegPGain, kp);
    write_reg(RegDGain, kd);
    if (poke) write_reg(RegUnused, CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : result_sink
    steer_result_t got;
    int            stall;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.left  = left_duty_o;
        got.right = right_duty_o;
        got.err   = line_error_o;
        got.marks = stop_marks_o;
        sb.check_duties(got);
        stall = idle_on ? $urandom_range(0, 6) : 0;
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    logic [PatW-1:0] pat, prev_pat;
    int              pick;
    prev_pat = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all bright, then all dark twice: the second dark set must not count
    drive_sample_set('1);
    drive_sample_set('0);
    drive_sample_set('0);
    foreach (DirectedPatterns[k]) drive_sample_set(samples_for(DirectedPatterns[k], 1'b1));
    // unlisted patterns hold the last error
    drive_sample_set(samples_for(5'd0, 1'b1));
    drive_sample_set(samples_for(5'd5, 1'b0));
    // second entry into all dark halts both motors
    drive_sample_set('0);
    drive_sample_set(samples_for(5'd1, 1'b0));
    drive_sample_set(samples_for(5'd4, 1'b0));
    drive_sample_set(samples_for(5'd16, 1'b0));

    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase > 0) begin
        settle();
        setup_phase(phase);
      end
      for (int n = 0; n < SetsPerPhase; n++) begin
        if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 30) pat = prev_pat;
        else if (pick < 80) pat = LinePatterns[$urandom_range(0, 8)];
        else if (pick < 85) pat = AllDark;
        else pat = PatW'($urandom);
        if (pick >= 93) drive_sample_set(noise_samples());
        else drive_sample_set(samples_for(pat, $urandom_range(0, 3) == 0));
        prev_pat = pat;
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
